// ===== hw/rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, constants and round functions shared by the SHA-256 hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } dig_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_DIGEST
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic       put;
    byte_src_t  src;
    logic       latch_len;
    logic       start;
    logic       round_en;
    logic [5:0] rnd;
    logic       add_chain;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       out_busy;
  } dp_status_t;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS       = 6'd56;
  localparam logic [5:0] LAST_POS      = 6'd63;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [3:0] DIGEST_WORDS  = 4'd8;

  localparam logic [31:0] INITIAL_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 of a byte stream, digest returned as eight 32-bit words.
// ----------------------------------------------------------------------------
// Message bytes are taken one item per cycle while a block fills. The item
// that completes a 64-byte block is followed by a stall: 64 rounds at one
// per cycle through the single round unit, then an add of the result into
// the chaining words. An end-of-message item starts padding, which moves
// bytes through the same block buffer (9 to 72 bytes, with one or two more
// compressions), and then the digest moves into an eight-word output
// buffer. Words leave that buffer at one per cycle as the receiver takes
// them, word 0 first, with digest_last on the eighth; the next message may
// be fed meanwhile, but its digest is handed to the buffer only once the
// buffer has drained.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_stall,
  input  msg_item_t msg,
  output logic      dig_valid,
  input  logic      dig_stall,
  output dig_item_t dig
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  sha256_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .byte_present   (msg.byte_present),
    .end_of_message (msg.end_of_message),
    .sts            (sts),
    .msg_stall      (msg_stall),
    .cmd            (cmd)
  );

  sha256_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .msg_byte  (msg.msg_byte),
    .dig_stall (dig_stall),
    .sts       (sts),
    .dig_valid (dig_valid),
    .dig       (dig)
  );

endmodule

// ===== hw/rtl/sha256_dp.sv =====
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: block/schedule shift line, round variables, chaining words,
// bit counter, length latch and the digest output buffer.
// ----------------------------------------------------------------------------
module sha256_dp import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  input  logic [7:0] msg_byte,
  input  logic       dig_stall,
  output dp_status_t sts,
  output logic       dig_valid,
  output dig_item_t  dig
);

  // The sixteen schedule words double as the 64-byte block buffer: bytes
  // shift in at the low byte of word 15, so word 0 ends up holding bytes 0 to 3.
  logic [31:0] w     [16];
  logic [31:0] v     [8];
  logic [31:0] chain [8];
  logic [31:0] obuf  [8];
  logic [63:0] bits;
  logic [63:0] len;
  logic [63:0] len_shifted;
  logic [3:0]  ocnt;
  logic [7:0]  put_val;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch_val;
  logic [31:0] maj_val;
  logic        dig_take;

  assign sts.pos      = bits[8:3];
  assign sts.out_busy = (ocnt != 4'd0);
  assign dig_valid    = (ocnt != 4'd0);
  assign dig_take     = dig_valid && !dig_stall;
  assign dig.digest_word = obuf[0];
  assign dig.digest_last = (ocnt == 4'd1);

  // Length bytes go out most significant first at positions 56 to 63.
  assign len_shifted = len << {sts.pos[2:0], 3'b000};

  always_comb begin
    case (cmd.src)
      SRC_MSG:  put_val = msg_byte;
      SRC_MARK: put_val = PAD_MARK_BYTE;
      SRC_ZERO: put_val = 8'h00;
      SRC_LEN:  put_val = len_shifted[63:56];
      default:  put_val = 8'h00;
    endcase
  end

  always_comb begin
    ch_val  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj_val = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1      = v[7] + big_sigma1(v[4]) + ch_val + ROUND_K[cmd.rnd] + w[0];
    t2      = big_sigma0(v[0]) + maj_val;
    w_new   = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      for (int j = 0; j < 15; j++) begin
        w[j] <= {w[j][23:0], w[j+1][31:24]};
      end
      w[15] <= {w[15][23:0], put_val};
    end else if (cmd.round_en) begin
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int j = 0; j < 8; j++) begin
        v[j] <= chain[j];
      end
    end else if (cmd.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int j = 0; j < 8; j++) begin
        chain[j] <= INITIAL_HASH[j];
      end
    end else if (cmd.add_chain) begin
      for (int j = 0; j < 8; j++) begin
        chain[j] <= chain[j] + v[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      bits <= 64'd0;
    end else if (cmd.put) begin
      bits <= bits + 64'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_len) begin
      len <= bits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int j = 0; j < 8; j++) begin
        obuf[j] <= chain[j];
      end
    end else if (dig_take) begin
      for (int j = 0; j < 7; j++) begin
        obuf[j] <= obuf[j+1];
      end
      obuf[7] <= obuf[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 4'd0;
    end else if (cmd.finish) begin
      ocnt <= DIGEST_WORDS;
    end else if (dig_take) begin
      ocnt <= ocnt - 4'd1;
    end
  end

endmodule

// ===== hw/rtl/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha256_ctrl
// Controller: accepts message items, sequences padding, the 64 rounds, the
// chaining add and the hand-off of the digest to the output buffer.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  input  logic       byte_present,
  input  logic       end_of_message,
  input  dp_status_t sts,
  output logic       msg_stall,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  ctrl_state_t ret, ret_next;
  logic [5:0]  rnd, rnd_next;
  logic        accept;

  assign accept = msg_valid && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (byte_present && sts.pos == LAST_POS) begin
            state_next = ST_ROUND;
            ret_next   = end_of_message ? ST_PAD_MARK : ST_IDLE;
          end else if (end_of_message) begin
            state_next = ST_PAD_MARK;
          end
        end
      end
      ST_ROUND: begin
        if (rnd == LAST_ROUND) state_next = ST_ADD;
      end
      ST_ADD: state_next = ret;
      ST_PAD_MARK: begin
        state_next = (sts.pos == LAST_POS) ? ST_ROUND : ST_PAD_ZERO;
        ret_next   = ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (sts.pos == LEN_POS) begin
          state_next = ST_PAD_LEN;
        end else if (sts.pos == LAST_POS) begin
          state_next = ST_ROUND;
          ret_next   = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        if (sts.pos == LAST_POS) begin
          state_next = ST_ROUND;
          ret_next   = ST_DIGEST;
        end
      end
      ST_DIGEST: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.src       = SRC_MSG;
    cmd.rnd       = rnd;
    msg_stall     = (state != ST_IDLE);
    rnd_next      = 6'd0;
    case (state)
      ST_IDLE: begin
        cmd.put   = accept && byte_present;
        cmd.start = accept && byte_present && (sts.pos == LAST_POS);
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 6'd1;
      end
      ST_ADD: cmd.add_chain = 1'b1;
      ST_PAD_MARK: begin
        cmd.put       = 1'b1;
        cmd.src       = SRC_MARK;
        cmd.latch_len = 1'b1;
        cmd.start     = (sts.pos == LAST_POS);
      end
      ST_PAD_ZERO: begin
        cmd.put   = (sts.pos != LEN_POS);
        cmd.src   = SRC_ZERO;
        cmd.start = (sts.pos == LAST_POS);
      end
      ST_PAD_LEN: begin
        cmd.put   = 1'b1;
        cmd.src   = SRC_LEN;
        cmd.start = (sts.pos == LAST_POS);
      end
      ST_DIGEST: cmd.finish = !sts.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      rnd   <= 6'd0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      rnd   <= rnd_next;
    end
  end

  // The round counter only moves inside a compression.
  a_rnd_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ROUND) |-> (rnd == 6'd0))
    else $error("round counter nonzero outside compression");

  // A compression begins only on the put of the last byte of a block.
  a_round_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == 6'd0) |-> $past(cmd.start))
    else $error("compression started without a full block");

  // Length bytes fill positions 56 to 63 only.
  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD_LEN) |-> (sts.pos >= LEN_POS))
    else $error("length bytes outside their field");

  // Handing off the digest clears the count and fills the output buffer.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (sts.pos == 6'd0 && sts.out_busy && state == ST_IDLE))
    else $error("digest hand-off left stale state");

endmodule
